// ----- rtl/core/lfc_pkg.sv -----
// Package: shared types and constants of the frame texture cache.
package lfc_pkg;

  localparam int unsigned KEY_IN_BITS   = 64;
  localparam int unsigned STAMP_IN_BITS = 48;
  localparam int unsigned SIZE_BITS     = 8;
  localparam int unsigned SLOT_BITS     = 6;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [KEY_IN_BITS-1:0]   frame_key;
    logic [STAMP_IN_BITS-1:0] use_stamp;
    logic                     decode_ok;
    logic [SIZE_BITS-1:0]     frame_width;
    logic [SIZE_BITS-1:0]     frame_height;
  } lfc_in_t;

  typedef struct packed {
    logic                 hit;
    logic                 failed;
    logic                 evicted;
    logic [SLOT_BITS-1:0] slot;
    logic [SIZE_BITS-1:0] entry_width;
    logic [SIZE_BITS-1:0] entry_height;
  } lfc_out_t;

  typedef struct packed {
    logic                 we;
    logic                 clear;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
  } lfc_wr_ctl_t;

endpackage

// ----- rtl/core/lfc_store.sv -----
// Entry store: key/stamp/size memory with one read and one write port, plus valid flops.
module lfc_store #(
  parameter int unsigned ENTRIES    = 48,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned STAMP_BITS = 48,
  parameter int unsigned IDX_W      = $clog2(ENTRIES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [IDX_W-1:0]              rd_idx_i,
  output logic                          rd_valid_o,
  output logic [KEY_BITS-1:0]           rd_key_o,
  output logic [STAMP_BITS-1:0]         rd_stamp_o,
  output logic [lfc_pkg::SIZE_BITS-1:0] rd_w_o,
  output logic [lfc_pkg::SIZE_BITS-1:0] rd_h_o,
  input  lfc_pkg::lfc_wr_ctl_t          wr_ctl_i,
  input  logic [IDX_W-1:0]              wr_idx_i,
  input  logic [KEY_BITS-1:0]           wr_key_i,
  input  logic [STAMP_BITS-1:0]         wr_stamp_i
);

  localparam int unsigned ENT_W = KEY_BITS + STAMP_BITS + 2 * lfc_pkg::SIZE_BITS;

  logic [ENT_W-1:0]   mem [ENTRIES];
  logic [ENT_W-1:0]   rdata_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_valid_q;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.we) begin
      mem[wr_idx_i] <= {wr_key_i, wr_stamp_i, wr_ctl_i.w, wr_ctl_i.h};
    end
    rdata_q <= mem[rd_idx_i];
  end

  // Track valid marks; clear empties all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_idx_i];
      if (wr_ctl_i.clear) begin
        valid_q <= '0;
      end else if (wr_ctl_i.we) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign {rd_key_o, rd_stamp_o, rd_w_o, rd_h_o} = rdata_q;

endmodule

// ----- rtl/core/lru_frame_texture_cache_top.sv -----
// Top level: fully associative frame cache with LRU replacement, scanned sequentially.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (lfc_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (lfc_out_t)
//
// A lookup scans all ENTRIES slots through the single memory read port, one
// per cycle, then passes through the drain and decide states to a loaded result.
// One transaction is in flight at a time.
// Reset empties every entry at once through the valid flops; no sweep follows.
// A stalled output holds the finished result; the block waits until it is taken.
module lru_frame_texture_cache_top #(
  parameter int unsigned ENTRIES    = 48,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned STAMP_BITS = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lfc_pkg::lfc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lfc_pkg::lfc_out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic                          p_vld_q, p_vld_d;
  logic [IDX_W-1:0]              p_idx_q, p_idx_d;
  lfc_pkg::lfc_in_t              req_q, req_d;
  logic                          hit_q, hit_d;
  logic [IDX_W-1:0]              hit_idx_q, hit_idx_d;
  logic [lfc_pkg::SIZE_BITS-1:0] hit_w_q, hit_w_d, hit_h_q, hit_h_d;
  logic                          free_q, free_d;
  logic [IDX_W-1:0]              free_idx_q, free_idx_d;
  logic                          min_have_q, min_have_d;
  logic [IDX_W-1:0]              min_idx_q, min_idx_d;
  logic [STAMP_BITS-1:0]         min_stamp_q, min_stamp_d;
  lfc_pkg::lfc_out_t             res_q, res_d;
  logic                          out_valid_q, out_valid_d;
  lfc_pkg::lfc_out_t             out_data_q, out_data_d;

  logic                          in_accept;
  logic                          out_load;
  logic [KEY_BITS-1:0]           req_key;
  logic [STAMP_BITS-1:0]         req_stamp;
  logic                          rd_valid;
  logic [KEY_BITS-1:0]           rd_key;
  logic [STAMP_BITS-1:0]         rd_stamp;
  logic [lfc_pkg::SIZE_BITS-1:0] rd_w, rd_h;
  logic                          key_match;
  logic                          stamp_less;
  lfc_pkg::lfc_wr_ctl_t          wr_ctl;
  logic [IDX_W-1:0]              wr_idx;
  logic [IDX_W-1:0]              target_idx;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  assign req_key   = KEY_BITS'(req_q.frame_key);
  assign req_stamp = STAMP_BITS'(req_q.use_stamp);

  // Shared compare unit: one stored entry against the request per cycle
  assign key_match  = rd_valid && (rd_key == req_key);
  assign stamp_less = rd_stamp < min_stamp_q;

  assign target_idx = free_q ? free_idx_q : min_idx_q;

  lfc_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .STAMP_BITS (STAMP_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_valid_o (rd_valid),
    .rd_key_o   (rd_key),
    .rd_stamp_o (rd_stamp),
    .rd_w_o     (rd_w),
    .rd_h_o     (rd_h),
    .wr_ctl_i   (wr_ctl),
    .wr_idx_i   (wr_idx),
    .wr_key_i   (req_key),
    .wr_stamp_i (req_stamp)
  );

  // Sequence the scan and form the result
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    p_vld_d     = 1'b0;
    p_idx_d     = p_idx_q;
    req_d       = req_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_w_d     = hit_w_q;
    hit_h_d     = hit_h_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    min_have_d  = min_have_q;
    min_idx_d   = min_idx_q;
    min_stamp_d = min_stamp_q;
    res_d       = res_q;
    wr_ctl      = '0;
    wr_idx      = target_idx;

    // Fold the entry read last cycle into the running records
    if (p_vld_q) begin
      if (key_match && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = p_idx_q;
        hit_w_d   = rd_w;
        hit_h_d   = rd_h;
      end
      if (!rd_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = p_idx_q;
      end
      if (rd_valid && (!min_have_q || stamp_less)) begin
        min_have_d  = 1'b1;
        min_idx_d   = p_idx_q;
        min_stamp_d = rd_stamp;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          req_d      = in_data_i;
          idx_d      = '0;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          min_have_d = 1'b0;
          if (in_data_i.op == lfc_pkg::OP_CLEAR) begin
            wr_ctl.clear = 1'b1;
            res_d        = '0;
            state_d      = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        p_vld_d = 1'b1;
        p_idx_d = idx_q;
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_d = '0;
        if (hit_q) begin
          // Refresh the stamp of the entry hit
          wr_ctl.we         = 1'b1;
          wr_ctl.w          = hit_w_q;
          wr_ctl.h          = hit_h_q;
          wr_idx            = hit_idx_q;
          res_d.hit         = 1'b1;
          res_d.slot        = lfc_pkg::SLOT_BITS'(hit_idx_q);
          res_d.entry_width  = hit_w_q;
          res_d.entry_height = hit_h_q;
        end else if (!req_q.decode_ok) begin
          res_d.failed = 1'b1;
        end else begin
          // Fill the first free slot, else replace the oldest entry
          wr_ctl.we          = 1'b1;
          wr_ctl.w           = req_q.frame_width;
          wr_ctl.h           = req_q.frame_height;
          wr_idx             = target_idx;
          res_d.evicted      = !free_q;
          res_d.slot         = lfc_pkg::SLOT_BITS'(target_idx);
          res_d.entry_width  = req_q.frame_width;
          res_d.entry_height = req_q.frame_height;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until the output side takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_vld_q     <= p_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    p_idx_q     <= p_idx_d;
    req_q       <= req_d;
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    hit_w_q     <= hit_w_d;
    hit_h_q     <= hit_h_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    min_have_q  <= min_have_d;
    min_idx_q   <= min_idx_d;
    min_stamp_q <= min_stamp_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
